### rtl/core/utf8ptc_pkg.sv
// Package for the UTF-8 plain text checker core.
// Holds the checker state type and the byte-class constants.
// No dependencies.
`timescale 1ns / 1ps

package utf8ptc_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned OutTdataW = 8;

    localparam logic [ByteW-1:0] ChTab      = 8'h09;
    localparam logic [ByteW-1:0] ChLf       = 8'h0A;
    localparam logic [ByteW-1:0] ChCr       = 8'h0D;
    localparam logic [ByteW-1:0] ChSpace    = 8'h20;
    localparam logic [ByteW-1:0] ChDel      = 8'h7F;
    localparam logic [ByteW-1:0] ChEdLead   = 8'hED;
    localparam logic [ByteW-1:0] MaskCont   = 8'hC0;
    localparam logic [ByteW-1:0] PatCont    = 8'h80;
    localparam logic [ByteW-1:0] MaskSurr   = 8'hA0;
    localparam logic [ByteW-1:0] MaskLead2  = 8'hE0;
    localparam logic [ByteW-1:0] PatLead2   = 8'hC0;
    localparam logic [ByteW-1:0] MaskLead3  = 8'hF0;
    localparam logic [ByteW-1:0] PatLead3   = 8'hE0;
    localparam logic [ByteW-1:0] MaskLead4  = 8'hF8;
    localparam logic [ByteW-1:0] PatLead4   = 8'hF0;

    typedef struct packed {
        logic [1:0] pend;
        logic       after_ed;
        logic       cr_pend;
        logic       failed;
    } t_state;

endpackage

### rtl/core/utf8_plain_text_checker_core.sv
// Each accepted byte waits in the input register; its result word is then
// registered in the result register and held there until it is read.
// Throughput: one byte per cycle while the output is not stalled; the input register
// advances whenever the result register is empty or being read, and otherwise holds its byte.
// Reset: synchronous, active low; clears both valid flags and the checker state.
// Top level of the UTF-8 plain text checker; uses utf8ptc_pkg, utf8ptc_step, utf8ptc_out_stage.
`timescale 1ns / 1ps

module utf8_plain_text_checker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [utf8ptc_pkg::ByteW-1:0]     i_s_axis_tdata,  // [7:0] data_byte
    input  logic                              i_s_axis_tlast,  // last
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [utf8ptc_pkg::OutTdataW-1:0] o_m_axis_tdata,  // [0] ok, [7:1] zero
    output logic                              o_m_axis_tlast   // done_res
);

    logic                          r_in_valid;
    logic [utf8ptc_pkg::ByteW-1:0] r_in_byte;
    logic                          r_in_last;
    utf8ptc_pkg::t_state           r_state;
    utf8ptc_pkg::t_state           n_state;
    logic                          w_ok;
    logic                          w_out_ready;
    logic                          w_adv;

    assign w_adv           = r_in_valid && w_out_ready;
    assign o_s_axis_tready = !r_in_valid || w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_state <= n_state;
            end
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    utf8ptc_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_ok    (w_ok)
    );

    utf8ptc_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_adv),
        .i_ok            (w_ok),
        .i_last          (r_in_last),
        .o_ready         (w_out_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

### rtl/core/utf8ptc_step.sv
// Next-state and verdict logic for one byte of the UTF-8 plain text checker.
// Purely combinational; uses utf8ptc_pkg.
`timescale 1ns / 1ps

module utf8ptc_step (
    input  utf8ptc_pkg::t_state          i_state,
    input  logic [utf8ptc_pkg::ByteW-1:0] i_byte,
    input  logic                          i_last,
    output utf8ptc_pkg::t_state          o_state,
    output logic                          o_ok
);

    utf8ptc_pkg::t_state w_mid;
    logic                w_ctrl_bad;
    logic                w_end_fail;

    assign w_ctrl_bad = ((i_byte < utf8ptc_pkg::ChSpace) && (i_byte != utf8ptc_pkg::ChTab)
                         && (i_byte != utf8ptc_pkg::ChLf) && (i_byte != utf8ptc_pkg::ChCr))
                        || (i_byte == utf8ptc_pkg::ChDel);

    always_comb begin
        w_mid = i_state;
        if (i_state.pend != 2'd0) begin
            if ((i_byte & utf8ptc_pkg::MaskCont) != utf8ptc_pkg::PatCont) begin
                w_mid.failed = 1'b1;
            end
            if (i_state.after_ed
                && ((i_byte & utf8ptc_pkg::MaskSurr) == utf8ptc_pkg::MaskSurr)) begin
                w_mid.failed = 1'b1;
            end
            w_mid.after_ed = 1'b0;
            w_mid.pend     = i_state.pend - 2'd1;
        end else begin
            if (i_state.cr_pend && (i_byte != utf8ptc_pkg::ChLf)) begin
                w_mid.failed = 1'b1;
            end
            w_mid.cr_pend  = 1'b0;
            w_mid.after_ed = 1'b0;
            if (w_ctrl_bad) begin
                w_mid.failed = 1'b1;
            end else if (i_byte <= utf8ptc_pkg::ChDel) begin
                w_mid.cr_pend = (i_byte == utf8ptc_pkg::ChCr);
            end else if ((i_byte & utf8ptc_pkg::MaskLead2) == utf8ptc_pkg::PatLead2) begin
                w_mid.pend = 2'd1;
            end else if ((i_byte & utf8ptc_pkg::MaskLead3) == utf8ptc_pkg::PatLead3) begin
                w_mid.pend     = 2'd2;
                w_mid.after_ed = (i_byte == utf8ptc_pkg::ChEdLead);
            end else if ((i_byte & utf8ptc_pkg::MaskLead4) == utf8ptc_pkg::PatLead4) begin
                w_mid.pend = 2'd3;
            end else begin
                w_mid.failed = 1'b1;
            end
        end
    end

    assign w_end_fail = i_last && ((w_mid.pend != 2'd0) || w_mid.cr_pend);
    assign o_ok       = !(w_mid.failed || w_end_fail);

    always_comb begin
        if (i_last) begin
            o_state = '0;
        end else begin
            o_state = w_mid;
        end
    end

endmodule

### rtl/core/utf8ptc_out_stage.sv
// Result register of the UTF-8 plain text checker with its stream handshake.
// Uses utf8ptc_pkg for the output word width.
`timescale 1ns / 1ps

module utf8ptc_out_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_ok,
    input  logic                              i_last,
    output logic                              o_ready,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [utf8ptc_pkg::OutTdataW-1:0] o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);

    logic r_valid;
    logic r_ok;
    logic r_last;

    assign o_ready = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ok   <= i_ok;
            r_last <= i_last;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {{(utf8ptc_pkg::OutTdataW-1){1'b0}}, r_ok};
    assign o_m_axis_tlast  = r_last;

endmodule

### rtl/core/utf8ptc_checker.sv
// Port-level assertions for the UTF-8 plain text checker core, bound to the top level.
// Uses utf8ptc_pkg for port widths.
`timescale 1ns / 1ps

module utf8ptc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [utf8ptc_pkg::OutTdataW-1:0] o_m_axis_tdata,
    input logic                              o_m_axis_tlast
);

    logic r_fail_seen;
    logic w_out_acc;

    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_seen <= 1'b0;
        end else if (w_out_acc) begin
            r_fail_seen <= !o_m_axis_tlast && !o_m_axis_tdata[0];
        end
    end

    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_fail_seen) |-> !o_m_axis_tdata[0])
        else $error("ok returned to 1 within a failed stream");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[utf8ptc_pkg::OutTdataW-1:1] == '0))
        else $error("padding bits of the result word are not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("block not idle after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled result word changed");

endmodule

bind utf8_plain_text_checker_core utf8ptc_checker u_utf8ptc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
